/* sv/sprf_pkg.sv */
// Shared types and constants for the stereo phase/ring/feedback modulation effect.
package sprf_pkg;

    localparam int BUF_DEPTH = 8192;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [BUF_AW-1:0] CENTRE_DELAY = BUF_AW'(2048);

    localparam logic [1:0] MODE_RING = 2'd1;
    localparam logic [1:0] MODE_FB   = 2'd2;

    localparam logic [2:0] CFG_DEPTH_TARGET = 3'd0;
    localparam logic [2:0] CFG_MODE         = 3'd1;
    localparam logic [2:0] CFG_MOD_GAIN     = 3'd2;
    localparam logic [2:0] CFG_DRY_GAIN     = 3'd3;
    localparam logic [2:0] CFG_WET_GAIN     = 3'd4;

    localparam int CFG_DW = 18;

    localparam logic signed [16:0] DECAY_MUL  = 17'sd32539;
    localparam logic signed [8:0]  SMOOTH_MUL = 9'sd131;
    localparam logic signed [39:0] FB_LIMIT   = 40'sd24576;

    typedef struct packed {
        logic signed [15:0] carrier_left;
        logic signed [15:0] carrier_right;
        logic signed [15:0] mod_left;
        logic signed [15:0] mod_right;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } out_t;

    typedef struct packed {
        logic wr;
        logic mul_m;
        logic mul_p;
        logic sum_p;
        logic pos;
        logic rd_a;
        logic rd_b;
        logic interp;
        logic wet;
        logic mix;
    } ctl_t;

endpackage

/* sv/sprf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module sprf_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/sprf_chan.sv */
// One channel: delay line, modulator scaling, interpolated read, ring product and mix.
module sprf_chan
    import sprf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  logic signed [15:0] carrier,
    input  logic signed [15:0] modin,
    input  logic [1:0]         mode,
    input  logic [15:0]        mod_gain,
    input  logic [15:0]        dry_gain,
    input  logic [15:0]        wet_gain,
    input  logic [27:0]        sd,
    input  logic [BUF_AW-1:0]  wi,
    input  logic               wrapped,
    output logic signed [15:0] sample
);

    logic signed [15:0] fb_reg;
    logic signed [32:0] m_reg;
    logic signed [47:0] p0_reg, p1_reg;
    logic signed [21:0] ring_reg;
    logic [28:0]        ofs_reg;
    logic [BUF_AW-1:0]  ia_reg;
    logic [15:0]        f_reg;
    logic               vld_reg;
    logic signed [15:0] a_reg;
    logic signed [33:0] dprod_reg;
    logic signed [21:0] wet_reg;
    logic signed [32:0] pd_reg;
    logic signed [38:0] pw_reg;

    logic signed [32:0] decay_prod;
    logic signed [15:0] fb_dec;
    logic signed [15:0] m_src;
    logic signed [48:0] ring_full;
    logic signed [57:0] prod;
    logic [28:0]        pos;
    logic [BUF_AW-1:0]  raddr;
    logic [15:0]        rdata;
    logic signed [15:0] rd_val;
    logic signed [16:0] diff;
    logic signed [33:0] dshift;
    logic signed [17:0] interp;
    logic signed [39:0] sum, sh;
    logic               is_fb, is_ring, quiet;

    assign is_fb   = (mode == MODE_FB);
    assign is_ring = (mode == MODE_RING);
    assign quiet   = (carrier >= -16'sd16) && (carrier <= 16'sd16);

    // decay toward zero, truncating
    assign decay_prod = fb_reg * DECAY_MUL;
    assign fb_dec     = 16'((decay_prod + (decay_prod < 0 ? 33'sd32767 : 33'sd0)) >>> 15);

    assign m_src     = is_fb ? fb_reg : modin;
    assign ring_full = carrier * m_reg;
    assign prod      = 58'(p0_reg) + (58'(p1_reg) <<< 14);
    assign pos       = {wi - CENTRE_DELAY, 16'd0} + ofs_reg;
    assign raddr     = ctl.rd_b ? ia_reg + BUF_AW'(1) : ia_reg;
    assign rd_val    = vld_reg ? $signed(rdata) : 16'sd0;
    assign diff      = 17'(rd_val) - 17'(a_reg);
    assign dshift    = dprod_reg >>> 16;
    assign interp    = 18'(a_reg) + 18'(dshift);

    sprf_ram #(.DEPTH(BUF_DEPTH), .WIDTH(16)) u_line (
        .clk   (clk),
        .we    (ctl.wr),
        .waddr (wi),
        .wdata (carrier),
        .re    (ctl.rd_a | ctl.rd_b),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= '0;
        end
        else if (ctl.wr && is_fb && quiet)
        begin
            fb_reg <= fb_dec;
        end
        else if (ctl.wet && is_fb)
        begin
            fb_reg <= interp[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_m)
        begin
            m_reg <= m_src * $signed({1'b0, mod_gain});
        end
        if (ctl.mul_p)
        begin
            p0_reg   <= m_reg * $signed({1'b0, sd[13:0]});
            p1_reg   <= m_reg * $signed({1'b0, sd[27:14]});
            ring_reg <= ring_full[47:26];
        end
        if (ctl.sum_p)
        begin
            ofs_reg <= prod[57:29];
        end
        if (ctl.pos)
        begin
            ia_reg <= pos[28:16];
            f_reg  <= pos[15:0];
        end
        // entries not yet written since reset read as zero
        if (ctl.rd_a || ctl.rd_b)
        begin
            vld_reg <= wrapped || (raddr <= wi);
        end
        if (ctl.rd_b)
        begin
            a_reg <= rd_val;
        end
        if (ctl.interp)
        begin
            dprod_reg <= diff * $signed({1'b0, f_reg});
        end
        if (ctl.wet)
        begin
            wet_reg <= is_ring ? ring_reg : 22'(interp);
        end
        if (ctl.mix)
        begin
            pd_reg <= carrier * $signed({1'b0, dry_gain});
            pw_reg <= wet_reg * $signed({1'b0, wet_gain});
        end
    end

    assign sum = 40'(pd_reg) + 40'(pw_reg) + 40'sd16384;
    assign sh  = sum >>> 15;

    always_comb
    begin
        if (is_fb && sh > FB_LIMIT)
        begin
            sample = 16'sd24576;
        end
        else if (is_fb && sh < -FB_LIMIT)
        begin
            sample = -16'sd24576;
        end
        else if (sh > 40'sd32767)
        begin
            sample = 16'sd32767;
        end
        else if (sh < -40'sd32768)
        begin
            sample = -16'sd32768;
        end
        else
        begin
            sample = sh[15:0];
        end
    end

endmodule

/* sv/stereo_phase_ring_fm_effect_top.sv */
// Top level of the stereo phase/ring/feedback modulation effect.
//
// Usage:
//   in_data carries one stereo request (carrier and modulator per channel);
//   it is taken at a clock edge where in_valid is high and in_stall is low.
//   out_data carries one stereo output frame, taken where out_valid is high
//   and out_stall is low. Exactly one output frame per input frame, in order.
//   Configuration is written through cfg_we/cfg_addr/cfg_data while idle:
//   index 0 depth target, 1 mode, 2 modulator gain, 3 dry gain, 4 wet gain.
//   The sequencer walks each frame through write, modulator and depth
//   multiplies, two reads of the single read port of each delay memory
//   (samples A and B), interpolation and mix; a new request is taken only
//   once the sequencer has returned to idle.
//   A finished frame waits in the output register; the next request is
//   accepted meanwhile, and the sequencer holds on its last step only if the
//   output register is still full when the next frame completes.
//   Reset returns the settings to defaults and the write index to zero. The delay
//   memories are not cleared: a fill mark (write index plus a wrap flag)
//   makes never-written entries read as zero, so no clearing pass is needed.
module stereo_phase_ring_fm_effect_top
    import sprf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_MUL_M, S_MUL_P, S_SUM_P, S_POS,
        S_RD_A, S_RD_B, S_INTERP, S_WET, S_MIX, S_ROUND
    } state_t;

    state_t state_reg, state_next;

    logic [17:0]       depth_target_reg;
    logic [1:0]        mode_reg;
    logic [15:0]       mod_gain_reg, dry_gain_reg, wet_gain_reg;
    logic [27:0]       sd_reg, sd_next;
    logic              primed_reg;
    logic [BUF_AW-1:0] wi_reg;
    logic              wrapped_reg;
    in_t               in_reg;
    out_t              out_reg;
    logic              out_valid_reg;

    logic              in_acc, done;
    ctl_t              ctl;
    logic signed [15:0] smp_l, smp_r;

    // depth smoothing: prime on the first frame, then one-pole step
    logic [27:0]        target, base;
    logic signed [28:0] d;
    logic signed [37:0] dp;
    logic signed [37:0] dq;

    assign target  = {depth_target_reg, 10'd0};
    assign base    = primed_reg ? sd_reg : target;
    assign d       = $signed({1'b0, target}) - $signed({1'b0, base});
    assign dp      = d * SMOOTH_MUL;
    assign dq      = (dp + (dp < 0 ? 38'sd65535 : 38'sd0)) >>> 16;
    assign sd_next = base + dq[27:0];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    // finish the frame only when the output register can take it
    assign done      = (state_reg == S_ROUND) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_WRITE;
            S_WRITE:  begin ctl.wr = 1'b1;     state_next = S_MUL_M;  end
            S_MUL_M:  begin ctl.mul_m = 1'b1;  state_next = S_MUL_P;  end
            S_MUL_P:  begin ctl.mul_p = 1'b1;  state_next = S_SUM_P;  end
            S_SUM_P:  begin ctl.sum_p = 1'b1;  state_next = S_POS;    end
            S_POS:    begin ctl.pos = 1'b1;    state_next = S_RD_A;   end
            S_RD_A:   begin ctl.rd_a = 1'b1;   state_next = S_RD_B;   end
            S_RD_B:   begin ctl.rd_b = 1'b1;   state_next = S_INTERP; end
            S_INTERP: begin ctl.interp = 1'b1; state_next = S_WET;    end
            S_WET:    begin ctl.wet = 1'b1;    state_next = S_MIX;    end
            S_MIX:    begin ctl.mix = 1'b1;    state_next = S_ROUND;  end
            S_ROUND:  if (done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            depth_target_reg <= 18'd12800;
            mode_reg         <= 2'd0;
            mod_gain_reg     <= 16'd4096;
            dry_gain_reg     <= 16'd23170;
            wet_gain_reg     <= 16'd23170;
            sd_reg           <= '0;
            primed_reg       <= 1'b0;
            wi_reg           <= '0;
            wrapped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_DEPTH_TARGET: depth_target_reg <= cfg_data;
                    CFG_MODE:         mode_reg         <= cfg_data[1:0];
                    CFG_MOD_GAIN:     mod_gain_reg     <= cfg_data[15:0];
                    CFG_DRY_GAIN:     dry_gain_reg     <= cfg_data[15:0];
                    CFG_WET_GAIN:     wet_gain_reg     <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            if (in_acc)
            begin
                sd_reg     <= sd_next;
                primed_reg <= 1'b1;
            end
            // advance the write index once per frame; mark the wrap
            if (done)
            begin
                wi_reg <= wi_reg + BUF_AW'(1);
                if (&wi_reg)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_reg <= in_data;
        end
        if (done)
        begin
            out_reg.out_left  <= smp_l;
            out_reg.out_right <= smp_r;
        end
    end

    sprf_chan u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .carrier  (in_reg.carrier_left),
        .modin    (in_reg.mod_left),
        .mode     (mode_reg),
        .mod_gain (mod_gain_reg),
        .dry_gain (dry_gain_reg),
        .wet_gain (wet_gain_reg),
        .sd       (sd_reg),
        .wi       (wi_reg),
        .wrapped  (wrapped_reg),
        .sample   (smp_l)
    );

    sprf_chan u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .carrier  (in_reg.carrier_right),
        .modin    (in_reg.mod_right),
        .mode     (mode_reg),
        .mod_gain (mod_gain_reg),
        .dry_gain (dry_gain_reg),
        .wet_gain (wet_gain_reg),
        .sd       (sd_reg),
        .wi       (wi_reg),
        .wrapped  (wrapped_reg),
        .sample   (smp_r)
    );

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_WRITE))
        else $error("accepted request did not start the sequencer");

    a_primed: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> primed_reg)
        else $error("depth smoothing not primed after a request");

    a_wi_step: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (wi_reg == $past(wi_reg) + BUF_AW'(1)))
        else $error("write index did not advance by one per frame");

    a_out_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid_reg)
        else $error("finished frame not presented");

endmodule
